[hdl/dtw_pkg.sv]
// Shared types, constants and month tables for the date to weekday and day of year block.
// No dependencies; used by hdl/date_to_weekday_and_day_of_year.sv.
package dtw_pkg;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_in_t;

  typedef struct packed {
    logic [2:0] day_of_week;
    logic [8:0] day_of_year;
    logic       date_valid;
  } date_out_t;

  // floor(x / 100) == (x * RecipHundred) >> RecipHundredShift for x below 43699
  localparam logic [12:0] RecipHundred      = 13'd5243;
  localparam int unsigned RecipHundredShift = 19;
  // floor(w / 7) == (w * RecipSeven) >> RecipSevenShift for w below 512
  localparam logic [8:0]  RecipSeven        = 9'd293;
  localparam int unsigned RecipSevenShift   = 11;

  localparam logic [12:0] YearBias   = 13'd400;
  localparam logic [3:0]  MonthJan   = 4'd1;
  localparam logic [3:0]  MonthFeb   = 4'd2;
  localparam logic [3:0]  MonthMar   = 4'd3;
  localparam logic [3:0]  MonthDec   = 4'd12;
  localparam logic [3:0]  MonthShift = 4'd12;

  typedef struct packed {
    logic [11:0] year;
    logic [6:0]  cy;
    logic [12:0] ay;
    logic [6:0]  ca;
    logic [3:0]  mz;
    logic [3:0]  month;
    logic [4:0]  day;
  } s2_t;

  typedef struct packed {
    logic       valid;
    logic [8:0] doy;
    logic [6:0] ya;
    logic [6:0] ca;
    logic [3:0] mz;
    logic [4:0] day;
  } s3_t;

  typedef struct packed {
    logic       valid;
    logic [8:0] doy;
    logic [8:0] w;
  } s4_t;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] cum;
    unique case (month)
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

  // floor(26 * (m + 1) / 10) for shifted months March (3) through February (14)
  function automatic logic [5:0] zeller_term(input logic [3:0] mz);
    logic [5:0] t;
    unique case (mz)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

[hdl/date_to_weekday_and_day_of_year.sv]
// Five-stage pipeline: Gregorian date to weekday (0 = Sunday) and ordinal day of year.
// Depends on hdl/dtw_pkg.sv for beat types, reciprocal constants and month tables.
//
// Takes one date beat per cycle while the output is not stalled and carries each one
// through the five register stages (input, divide by 100, leap/check/day of year,
// Zeller sum, modulo 7 and output). Each stage moves on when the one after it is empty
// or moving, so bubbles collapse and a stalled output only holds the input back once
// every stage is full. A month outside 1..12, day zero or a day past the month end gives
// date_valid low and zero in the other fields.
module date_to_weekday_and_day_of_year (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dtw_pkg::date_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dtw_pkg::date_out_t out_data_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic adv1, adv2, adv3, adv4, adv5;

  dtw_pkg::date_in_t  s1_q;
  dtw_pkg::s2_t       s2_d, s2_q;
  dtw_pkg::s3_t       s3_d, s3_q;
  dtw_pkg::s4_t       s4_d, s4_q;
  dtw_pkg::date_out_t s5_d, s5_q;

  logic [12:0] ay;
  logic [25:0] prod_y, prod_a;
  logic [11:0] ry;
  logic [12:0] ya_full;
  logic        leap;
  logic [4:0]  len;
  logic [17:0] prod_w;
  logic [6:0]  q7;
  logic [8:0]  rem7;

  assign adv5 = !v5_q || !out_stall_i;
  assign adv4 = !v4_q || adv5;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_stall_o  = !adv1;
  assign out_valid_o = v5_q;
  assign out_data_o  = s5_q;

  // divide year and shifted year by 100
  always_comb begin
    ay = {1'b0, s1_q.year} + dtw_pkg::YearBias
         - ((s1_q.month < dtw_pkg::MonthMar) ? 13'd1 : 13'd0);
    prod_y = 26'(s1_q.year) * 26'(dtw_pkg::RecipHundred);
    prod_a = 26'(ay) * 26'(dtw_pkg::RecipHundred);
    s2_d.year  = s1_q.year;
    s2_d.cy    = 7'(prod_y >> dtw_pkg::RecipHundredShift);
    s2_d.ay    = ay;
    s2_d.ca    = 7'(prod_a >> dtw_pkg::RecipHundredShift);
    s2_d.mz    = (s1_q.month < dtw_pkg::MonthMar) ? s1_q.month + dtw_pkg::MonthShift
                                                  : s1_q.month;
    s2_d.month = s1_q.month;
    s2_d.day   = s1_q.day;
  end

  // leap year, range check, day of year, year within century
  always_comb begin
    ry      = s2_q.year - 12'(s2_q.cy) * 12'd100;
    leap    = (ry == 12'd0) ? (s2_q.cy[1:0] == 2'd0) : (s2_q.year[1:0] == 2'd0);
    len     = dtw_pkg::month_days(s2_q.month, leap);
    ya_full = s2_q.ay - 13'(s2_q.ca) * 13'd100;
    s3_d.valid = (s2_q.month >= dtw_pkg::MonthJan) && (s2_q.month <= dtw_pkg::MonthDec)
                 && (s2_q.day != 5'd0) && (s2_q.day <= len);
    s3_d.doy   = 9'(s2_q.day) + dtw_pkg::days_before(s2_q.month)
                 + ((leap && (s2_q.month > dtw_pkg::MonthFeb)) ? 9'd1 : 9'd0);
    s3_d.ya    = ya_full[6:0];
    s3_d.ca    = s2_q.ca;
    s3_d.mz    = s2_q.mz;
    s3_d.day   = s2_q.day;
  end

  // Zeller sum, -2c taken as +5c
  always_comb begin
    s4_d.valid = s3_q.valid;
    s4_d.doy   = s3_q.doy;
    s4_d.w     = 9'(s3_q.ya) + 9'(s3_q.ya[6:2]) + 9'(s3_q.ca[6:2]) + 9'(s3_q.ca) * 9'd5
                 + 9'(dtw_pkg::zeller_term(s3_q.mz)) + 9'(s3_q.day) - 9'd1;
  end

  // reduce modulo 7, clear fields of an invalid date
  always_comb begin
    prod_w = 18'(s4_q.w) * 18'(dtw_pkg::RecipSeven);
    q7     = 7'(prod_w >> dtw_pkg::RecipSevenShift);
    rem7   = s4_q.w - 9'(q7) * 9'd7;
    s5_d.date_valid  = s4_q.valid;
    s5_d.day_of_week = s4_q.valid ? rem7[2:0] : 3'd0;
    s5_d.day_of_year = s4_q.valid ? s4_q.doy : 9'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
      if (adv5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) s1_q <= in_data_i;
    if (adv2) s2_q <= s2_d;
    if (adv3) s3_q <= s3_d;
    if (adv4) s4_q <= s4_d;
    if (adv5) s5_q <= s5_d;
  end

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.date_valid) |->
      (out_data_o.day_of_week == 3'd0 && out_data_o.day_of_year == 9'd0))
    else $error("invalid date beat carries nonzero fields");

  a_valid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.date_valid) |->
      (out_data_o.day_of_week <= 3'd6 && out_data_o.day_of_year != 9'd0
       && out_data_o.day_of_year <= 9'd366))
    else $error("valid date beat out of range");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && v3_q && v4_q && v5_q && out_stall_i) |-> in_stall_o)
    else $error("input not stalled with full pipeline");

  a_hold_stage4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !adv4) |=> (v4_q && $stable(s4_q)))
    else $error("stage four changed while held");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && s4_q.valid) |-> (s4_q.w <= 9'd423))
    else $error("Zeller sum out of bounds");

endmodule

[test/tb_top.sv]
// Testbench for date_to_weekday_and_day_of_year: directed date table, then random dates.
// Checks every output beat against a pinned value or a weekday/ordinal-day predictor.
// Depends on hdl/dtw_pkg.sv and hdl/date_to_weekday_and_day_of_year.sv.
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic               pinned;
    dtw_pkg::date_out_t want;
  } pin_t;

  typedef struct packed {
    logic               pinned;
    dtw_pkg::date_out_t want;
    dtw_pkg::date_in_t  d;
  } probe_t;

  localparam logic               Pinned    = 1'b1;
  localparam logic               Open      = 1'b0;
  localparam dtw_pkg::date_out_t NoDate    = '0;
  localparam int                 NumProbes = 24;
  localparam int                 NumRandom = 500;

  localparam int unsigned MonthLen [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  localparam probe_t ProbeTab [NumProbes] = '{
    {Pinned, 3'd6, 9'd1,   1'b1, 12'd2000, 4'd1,  5'd1},
    {Pinned, 3'd0, 9'd366, 1'b1, 12'd2000, 4'd12, 5'd31},
    {Open,   NoDate,             12'd2000, 4'd2,  5'd29},
    {Pinned, NoDate,             12'd1900, 4'd2,  5'd29},
    {Open,   NoDate,             12'd2024, 4'd2,  5'd29},
    {Pinned, NoDate,             12'd2023, 4'd2,  5'd29},
    {Open,   NoDate,             12'd2023, 4'd12, 5'd31},
    {Open,   NoDate,             12'd0,    4'd1,  5'd1},
    {Open,   NoDate,             12'd0,    4'd2,  5'd29},
    {Open,   NoDate,             12'd0,    4'd12, 5'd31},
    {Open,   NoDate,             12'd4095, 4'd12, 5'd31},
    {Open,   NoDate,             12'd4095, 4'd2,  5'd28},
    {Pinned, NoDate,             12'd4095, 4'd2,  5'd29},
    {Pinned, NoDate,             12'd2023, 4'd0,  5'd1},
    {Pinned, NoDate,             12'd2023, 4'd13, 5'd1},
    {Pinned, NoDate,             12'd4095, 4'd15, 5'd31},
    {Pinned, NoDate,             12'd2023, 4'd6,  5'd0},
    {Pinned, NoDate,             12'd2023, 4'd4,  5'd31},
    {Pinned, NoDate,             12'd2000, 4'd2,  5'd30},
    {Pinned, NoDate,             12'd2100, 4'd2,  5'd29},
    {Open,   NoDate,             12'd2400, 4'd3,  5'd1},
    {Open,   NoDate,             12'd1,    4'd1,  5'd1},
    {Open,   NoDate,             12'd2023, 4'd11, 5'd30},
    {Open,   NoDate,             12'd1583, 4'd10, 5'd15}
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  dtw_pkg::date_in_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  dtw_pkg::date_out_t out_data_o;

  pin_t               pinned_q [$];
  dtw_pkg::date_out_t due_results_q [$];
  int unsigned n_dates_sent   = 0;
  int unsigned n_accepted     = 0;
  int unsigned n_results_seen = 0;
  int unsigned n_valid_seen   = 0;
  int unsigned n_bad          = 0;
  int unsigned calm_left      = 0;
  int unsigned stall_left     = 0;

  date_to_weekday_and_day_of_year dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic is_leap_year(int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned days_in(int unsigned mo, logic leap);
    return (mo == 2 && leap) ? 29 : MonthLen[mo - 1];
  endfunction

  function automatic dtw_pkg::date_out_t weekday_and_ordinal(dtw_pkg::date_in_t d);
    dtw_pkg::date_out_t res;
    int unsigned        yr, mo, dy, doy, ay, mz, c, yy, w;
    logic               leap;
    res  = '0;
    yr   = 32'(d.year);
    mo   = 32'(d.month);
    dy   = 32'(d.day);
    leap = is_leap_year(yr);
    if (mo < 1 || mo > 12 || dy == 0) return res;
    if (dy > days_in(mo, leap)) return res;
    doy = dy;
    for (int i = 1; i < mo; i++) doy += days_in(i, leap);
    // shift Jan/Feb to months 13/14 of the prior year; bias by 400 years
    ay = yr + 400;
    mz = mo;
    if (mz < 3) begin
      mz += 12;
      ay -= 1;
    end
    c = ay / 100;
    yy = ay % 100;
    w = yy + yy / 4 + c / 4 + 5 * c + (26 * (mz + 1)) / 10 + dy - 1;
    res.day_of_week = 3'(w % 7);
    res.day_of_year = 9'(doy);
    res.date_valid  = 1'b1;
    return res;
  endfunction

  function automatic dtw_pkg::date_in_t random_date();
    dtw_pkg::date_in_t d;
    int unsigned       pick, yr, mo, len;
    pick = $urandom_range(0, 9);
    if (pick < 6) yr = $urandom_range(0, 4095);
    else if (pick < 8) yr = 100 * $urandom_range(0, 40) + $urandom_range(0, 4);
    else yr = 4 * $urandom_range(0, 1023);
    d.year = 12'(yr);
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      mo = $urandom_range(1, 12);
      len = days_in(mo, is_leap_year(yr));
      d.month = 4'(mo);
      d.day = 5'(($urandom_range(0, 3) == 0) ? len : $urandom_range(1, len));
    end else if (pick < 90) begin
      d.month = 4'($urandom_range(0, 15));
      d.day = 5'($urandom_range(0, 31));
    end else begin
      mo = $urandom_range(1, 12);
      len = days_in(mo, is_leap_year(yr));
      d.month = 4'(mo);
      d.day = 5'((len == 31 || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(len + 1, 31));
    end
    return d;
  endfunction

  function automatic int unsigned idle_span();
    int unsigned pick;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) calm_left = $urandom_range(20, 60);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic send_date(dtw_pkg::date_in_t d, pin_t pin);
    int unsigned gap;
    gap = idle_span();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pinned_q.push_back(pin);
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    n_dates_sent++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned pick;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        out_stall_i <= 1'b1;
        stall_left = (pick < 36) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end else begin
        out_stall_i <= 1'b0;
        stall_left = (pick < 90) ? $urandom_range(0, 8) : $urandom_range(30, 80);
      end
    end
  end

  always @(posedge clk_i) begin
    pin_t               pin;
    dtw_pkg::date_out_t want;
    dtw_pkg::date_out_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pin = pinned_q.pop_front();
        due_results_q.push_back(pin.pinned ? pin.want : weekday_and_ordinal(in_data_i));
        n_accepted++;
      end
      if (out_valid_o && !out_stall_i) begin
        got = out_data_o;
        n_results_seen++;
        if (got.date_valid) n_valid_seen++;
        if (due_results_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("ERROR: unexpected beat dow=%0d doy=%0d valid=%0b",
                     got.day_of_week, got.day_of_year, got.date_valid);
        end else begin
          want = due_results_q.pop_front();
          if (got.day_of_week !== want.day_of_week || got.day_of_year !== want.day_of_year ||
              got.date_valid !== want.date_valid) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"ERROR: beat %0d exp dow=%0d doy=%0d valid=%0b, ",
                        "got dow=%0d doy=%0d valid=%0b"},
                       n_results_seen, want.day_of_week, want.day_of_year, want.date_valid,
                       got.day_of_week, got.day_of_year, got.date_valid);
          end
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < NumProbes; i++)
      send_date(ProbeTab[i].d, {ProbeTab[i].pinned, ProbeTab[i].want});
    for (int i = 0; i < NumRandom; i++) begin
      // drain the pipe once mid-run
      if (i == NumRandom / 2) begin
        in_valid_i <= 1'b0;
        while (n_results_seen < n_dates_sent) @(posedge clk_i);
      end
      send_date(random_date(), '0);
    end
    in_valid_i <= 1'b0;
    while (n_results_seen < n_dates_sent) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (due_results_q.size() != 0) begin
      n_bad += due_results_q.size();
      $display("ERROR: %0d results never arrived", due_results_q.size());
    end
    $display("Sent %0d dates (%0d directed, %0d random), checked %0d results.",
             n_dates_sent, NumProbes, NumRandom, n_results_seen);
    $display("Valid dates: %0d, rejected dates: %0d, mismatches: %0d.",
             n_valid_seen, n_results_seen - n_valid_seen, n_bad);
    if (n_bad == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3_200_000;
    $display("ERROR: timeout with %0d results outstanding", n_accepted - n_results_seen);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
